// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/bsoc_pkg.sv -----
package bsoc_pkg;

   localparam logic [15:0] TABLE_MIN_MV   = 16'd2700;
   localparam logic [10:0] TABLE_LAST_OFF = 11'd1499;
   localparam logic [15:0] MV_PER_STEP    = 16'd50;
   localparam logic [15:0] COUNTS_PER_MAH = 16'd20000;
   localparam logic [15:0] CAPACITY_RESET = 16'd5600;
   localparam logic [6:0]  PCT_SAT        = 7'd127;
   localparam logic [6:0]  PCT_FULL       = 7'd100;

   localparam logic [5:0] OFF_BITS    = 6'd11;
   localparam logic [5:0] INTERP_BITS = 6'd9;
   localparam logic [5:0] MAH_BITS    = 6'd32;
   localparam logic [5:0] PCT_BITS    = 6'd25;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_OFF_DIV,
      ST_INTERP_MUL,
      ST_INTERP_DIV,
      ST_MAH_LOAD,
      ST_MAH_DIV,
      ST_PCT_MUL,
      ST_PCT_DIV,
      ST_FINISH
   } state_type;

   // Resting charge in percent at 50 mV steps starting at 2700 mV.
   function automatic logic [6:0] ocv_point(input logic [4:0] idx);
      logic [6:0] pct;
      case (idx)
         5'd0:    pct = 7'd0;
         5'd1:    pct = 7'd0;
         5'd2:    pct = 7'd0;
         5'd3:    pct = 7'd0;
         5'd4:    pct = 7'd1;
         5'd5:    pct = 7'd2;
         5'd6:    pct = 7'd3;
         5'd7:    pct = 7'd4;
         5'd8:    pct = 7'd5;
         5'd9:    pct = 7'd7;
         5'd10:   pct = 7'd8;
         5'd11:   pct = 7'd11;
         5'd12:   pct = 7'd14;
         5'd13:   pct = 7'd16;
         5'd14:   pct = 7'd18;
         5'd15:   pct = 7'd19;
         5'd16:   pct = 7'd25;
         5'd17:   pct = 7'd30;
         5'd18:   pct = 7'd33;
         5'd19:   pct = 7'd37;
         5'd20:   pct = 7'd43;
         5'd21:   pct = 7'd48;
         5'd22:   pct = 7'd53;
         5'd23:   pct = 7'd60;
         5'd24:   pct = 7'd67;
         5'd25:   pct = 7'd71;
         5'd26:   pct = 7'd76;
         5'd27:   pct = 7'd82;
         5'd28:   pct = 7'd92;
         5'd29:   pct = 7'd97;
         5'd30:   pct = 7'd100;
         default: pct = 7'd100;
      endcase
      return pct;
   endfunction

endpackage

// ----- hdl/battery_state_of_charge_gauge_top.sv -----
// Battery state-of-charge gauge.
// Input channel (req_*): one cell voltage per beat, req_last_cell marks the
// final cell of a frame; only the charge counters on that beat are used.
// Result channel (rsp_*): one beat per frame whose first cell is nonzero.
// Configuration: csr_wr_en writes csr_wr_data into the capacity register at
// once; write it only while no frame is in flight.
// Operation: a cell that is not last is taken in ST_IDLE, and so is the closing
// cell of a frame whose first cell read zero. A valid closing cell runs
// through one shared shift-subtract divider, one quotient bit per cycle: a
// load step, 32 quotient bits for the mAh count, a multiply step, 25 quotient
// bits for the percent and a finish step. The first valid frame adds the table
// lookup before these (a clamp step, 11 quotient bits, an interpolation
// multiply step and 9 quotient bits). req_ready is low from the closing cell
// until the finish step hands the result to the output register.
// Reset: capacity returns to 5600 mAh, the resting charge is forgotten and
// the next cell opens a frame.
// Stall: the result sits in an output register; new cells are taken while it
// waits, and a later result waits in the last step until that register frees.
module battery_state_of_charge_gauge_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_cell_mv,
   input  logic        req_last_cell,
   input  logic [31:0] req_trip_used_raw,
   input  logic [31:0] req_trip_regen_raw,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_soc_percent,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import bsoc_pkg::*;

   state_type   state_ff, state_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] diff_ff, diff_in;
   logic [15:0] lowest_ff, lowest_in;
   logic        awaiting_ff, awaiting_in;
   logic        first_zero_ff, first_zero_in;
   logic        latched_ff, latched_in;
   logic [6:0]  rest_ff, rest_in;
   logic [6:0]  left_ff, left_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_soc_ff, rsp_soc_in;
   logic [15:0] capacity_ff, capacity_in;

   logic        accept;
   logic        dividing;
   logic [16:0] trial;
   logic [16:0] trial_diff;
   logic        trial_ge;
   logic [31:0] step_quo;
   logic [15:0] step_rem;
   logic [15:0] off_full;
   logic [10:0] off;
   logic [6:0]  right_pct;
   logic [8:0]  interp_prod;
   logic [24:0] pct_prod;
   logic [7:0]  rest_sum;
   logic [6:0]  pct_sat;
   logic [6:0]  soc;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_soc_percent = rsp_soc_ff;
   assign dividing        = (state_ff == ST_MAH_DIV) || (state_ff == ST_PCT_DIV) ||
                            (state_ff == ST_OFF_DIV) || (state_ff == ST_INTERP_DIV);

   // One restoring divide step: shift in the next dividend bit, trial subtract.
   assign trial      = {rem_ff, quo_ff[31]};
   assign trial_diff = trial - {1'b0, dsr_ff};
   assign trial_ge   = (trial >= {1'b0, dsr_ff});
   assign step_rem   = trial_ge ? trial_diff[15:0] : trial[15:0];
   assign step_quo   = {quo_ff[30:0], trial_ge};

   assign off_full  = (lowest_ff < TABLE_MIN_MV) ? 16'd0 : lowest_ff - TABLE_MIN_MV;
   assign off       = (off_full > {5'd0, TABLE_LAST_OFF}) ? TABLE_LAST_OFF : off_full[10:0];
   assign right_pct = ocv_point(quo_ff[4:0] + 5'd1);
   assign interp_prod = {2'd0, right_pct - ocv_point(quo_ff[4:0])} * {3'd0, rem_ff[5:0]};
   assign pct_prod  = {7'd0, quo_ff[17:0]} * 25'd100;
   assign rest_sum  = {1'b0, left_ff} + {4'd0, quo_ff[3:0]};
   assign pct_sat   = (|quo_ff[31:7]) ? PCT_SAT : quo_ff[6:0];
   assign soc       = (pct_sat >= rest_ff) ? 7'd0 : rest_ff - pct_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         awaiting_ff   <= 1'b1;
         first_zero_ff <= 1'b0;
         latched_ff    <= 1'b0;
         rest_ff       <= 7'd0;
         rsp_valid_ff  <= 1'b0;
         capacity_ff   <= CAPACITY_RESET;
      end else begin
         state_ff      <= state_in;
         awaiting_ff   <= awaiting_in;
         first_zero_ff <= first_zero_in;
         latched_ff    <= latched_in;
         rest_ff       <= rest_in;
         rsp_valid_ff  <= rsp_valid_in;
         capacity_ff   <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      cnt_ff     <= cnt_in;
      diff_ff    <= diff_in;
      lowest_ff  <= lowest_in;
      left_ff    <= left_in;
      rsp_soc_ff <= rsp_soc_in;
   end

   always_comb begin
      state_in      = state_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      cnt_in        = cnt_ff;
      diff_in       = diff_ff;
      lowest_in     = lowest_ff;
      awaiting_in   = awaiting_ff;
      first_zero_in = first_zero_ff;
      latched_in    = latched_ff;
      rest_in       = rest_ff;
      left_in       = left_ff;
      rsp_soc_in    = rsp_soc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      capacity_in   = csr_wr_en ? csr_wr_data : capacity_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (awaiting_ff) begin
                  lowest_in     = req_cell_mv;
                  first_zero_in = (req_cell_mv == 16'd0);
               end else if (req_cell_mv < lowest_ff) begin
                  lowest_in = req_cell_mv;
               end
               awaiting_in = req_last_cell;
               diff_in     = req_trip_used_raw - req_trip_regen_raw;
               if (req_last_cell) begin
                  if (awaiting_ff ? (req_cell_mv != 16'd0) : !first_zero_ff) begin
                     state_in = latched_ff ? ST_MAH_LOAD : ST_CLAMP;
                  end
               end
            end
         end
         ST_CLAMP: begin
            quo_in   = {off, 21'd0};
            rem_in   = 16'd0;
            dsr_in   = MV_PER_STEP;
            cnt_in   = OFF_BITS;
            state_in = ST_OFF_DIV;
         end
         ST_INTERP_MUL: begin
            // Table step index is in the quotient, the mV within the step in rem.
            left_in  = ocv_point(quo_ff[4:0]);
            quo_in   = {interp_prod, 23'd0};
            rem_in   = 16'd0;
            dsr_in   = MV_PER_STEP;
            cnt_in   = INTERP_BITS;
            state_in = ST_INTERP_DIV;
         end
         ST_MAH_LOAD: begin
            if (!latched_ff) begin
               rest_in    = (rest_sum > {1'b0, PCT_FULL}) ? PCT_FULL : rest_sum[6:0];
               latched_in = 1'b1;
            end
            quo_in   = diff_ff;
            rem_in   = 16'd0;
            dsr_in   = COUNTS_PER_MAH;
            cnt_in   = MAH_BITS;
            state_in = ST_MAH_DIV;
         end
         ST_PCT_MUL: begin
            quo_in   = {pct_prod, 7'd0};
            rem_in   = 16'd0;
            dsr_in   = capacity_ff;
            cnt_in   = PCT_BITS;
            state_in = ST_PCT_DIV;
         end
         ST_OFF_DIV, ST_INTERP_DIV, ST_MAH_DIV, ST_PCT_DIV: begin
            quo_in = step_quo;
            rem_in = step_rem;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               case (state_ff)
                  ST_OFF_DIV:    state_in = ST_INTERP_MUL;
                  ST_INTERP_DIV: state_in = ST_MAH_LOAD;
                  ST_MAH_DIV:    state_in = ST_PCT_MUL;
                  default:       state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_soc_in   = soc;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_soc_range, clock, reset, rsp_valid_ff, rsp_soc_ff <= PCT_FULL)
   `ASSERT_IMPLIES(a_rest_range, clock, reset, latched_ff, rest_ff <= PCT_FULL)
   `ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `ASSERT_IMPLIES(a_div_count, clock, reset, dividing, cnt_ff != 6'd0)

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

   localparam int PREDICT       = -1;
   localparam int SETTLE_CYCLES = 120;
   localparam int DIRECTED_ROWS = 20;

   // Open-circuit voltage curve, percent at 50 mV steps from 2700 mV.
   localparam logic [6:0] REST_CURVE [31] = '{
      7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd2,  7'd3,  7'd4,  7'd5,  7'd7,  7'd8,
      7'd11, 7'd14, 7'd16, 7'd18, 7'd19, 7'd25, 7'd30, 7'd33, 7'd37, 7'd43, 7'd48,
      7'd53, 7'd60, 7'd67, 7'd71, 7'd76, 7'd82, 7'd92, 7'd97, 7'd100
   };

   typedef enum logic {ROW_CELL, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  mv;
      logic [15:0]  cap;
      logic         last;
      logic [31:0]  used;
      logic [31:0]  regen;
      int           want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_cell_mv = 16'd0;
   logic        req_last_cell = 1'b0;
   logic [31:0] req_trip_used_raw = 32'd0;
   logic [31:0] req_trip_regen_raw = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_soc_percent;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   battery_state_of_charge_gauge_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cell_mv        (req_cell_mv),
      .req_last_cell      (req_last_cell),
      .req_trip_used_raw  (req_trip_used_raw),
      .req_trip_regen_raw (req_trip_regen_raw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_soc_percent    (rsp_soc_percent),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // Gauge state as the block should hold it.
   logic [15:0] cap_mah = 16'd5600;
   logic [15:0] frame_min_mv = 16'd0;
   bit          frame_starting = 1'b1;
   bit          frame_dead = 1'b0;
   bit          rest_known = 1'b0;
   logic [6:0]  rest_pct = 7'd0;

   logic [6:0]  soc_expected [$];
   logic [6:0]  soc_due;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatch_count = 0;
   int          cells_accepted = 0;
   int          frames_closed = 0;
   int          readings_checked = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_CELL,     16'd0,     16'd0,     1'b1, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd0,     16'd0,     1'b0, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd4000,  16'd0,     1'b0, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd65535, 16'd0,     1'b1, 32'hFFFF_FFFF,  32'd0,          PREDICT},
      '{ROW_CELL,     16'd65535, 16'd0,     1'b0, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd4199,  16'd0,     1'b0, 32'hFFFF_FFFF,  32'd0,          PREDICT},
      '{ROW_CELL,     16'd4400,  16'd0,     1'b1, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd2000,  16'd0,     1'b1, 32'd0,          32'd1,          0},
      '{ROW_CELL,     16'd3000,  16'd0,     1'b1, 32'd112000000,  32'd0,          0},
      '{ROW_CELL,     16'd3001,  16'd0,     1'b1, 32'd1119999,    32'd0,          PREDICT},
      '{ROW_CELL,     16'd3002,  16'd0,     1'b1, 32'd1120000,    32'd0,          PREDICT},
      '{ROW_CELL,     16'd3003,  16'd0,     1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  PREDICT},
      '{ROW_CAPACITY, 16'd0,     16'd0,     1'b0, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd3100,  16'd0,     1'b1, 32'd0,          32'd0,          0},
      '{ROW_CAPACITY, 16'd0,     16'd65535, 1'b0, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd3200,  16'd0,     1'b1, 32'd1310700000, 32'd0,          0},
      '{ROW_CELL,     16'd3300,  16'd0,     1'b1, 32'd40000000,   32'd0,          PREDICT},
      '{ROW_CAPACITY, 16'd0,     16'd1,     1'b0, 32'd0,          32'd0,          PREDICT},
      '{ROW_CELL,     16'd3400,  16'd0,     1'b1, 32'd20000,      32'd0,          0},
      '{ROW_CELL,     16'd3500,  16'd0,     1'b1, 32'd19999,      32'd0,          PREDICT}
   };

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [6:0] resting_pct(input logic [15:0] mv);
      int unsigned off;
      int unsigned scaled;
      int unsigned seg;
      int unsigned frac;
      int unsigned lo;
      int unsigned hi;
      int unsigned r;
      off = (mv < 16'd2700) ? 0 : int'(mv) - 2700;
      if (off > 1499) off = 1499;
      scaled = off * 30;
      seg = scaled / 1500;
      if (seg > 29) seg = 29;
      frac = scaled % 1500;
      lo = REST_CURVE[seg];
      hi = REST_CURVE[seg + 1];
      r = lo + ((hi - lo) * frac) / 1500;
      if (r > 100) r = 100;
      return r[6:0];
   endfunction

   // Advances the gauge state by one cell; returns 1 when the cell yields a reading.
   function automatic bit gauge_update(input logic [15:0] mv, input logic last,
                                       input logic [31:0] used, input logic [31:0] regen,
                                       output logic [6:0] soc);
      logic [31:0] net;
      int unsigned mah;
      int unsigned pct;
      soc = 7'd0;
      if (frame_starting) begin
         frame_min_mv = mv;
         frame_dead = (mv == 16'd0);
         frame_starting = 1'b0;
      end else if (mv < frame_min_mv) begin
         frame_min_mv = mv;
      end
      if (!last) return 1'b0;
      frame_starting = 1'b1;
      if (frame_dead) return 1'b0;
      if (!rest_known) begin
         rest_pct = resting_pct(frame_min_mv);
         rest_known = 1'b1;
      end
      net = used - regen;
      mah = net / 32'd20000;
      if (cap_mah == 16'd0) begin
         pct = 127;
      end else begin
         pct = (mah * 100) / cap_mah;
         if (pct > 127) pct = 127;
      end
      soc = (pct >= rest_pct) ? 7'd0 : rest_pct - pct[6:0];
      return 1'b1;
   endfunction

   task automatic send_cell(input logic [15:0] mv, input logic last,
                            input logic [31:0] used, input logic [31:0] regen,
                            input int want);
      logic [6:0] soc;
      if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_idle_pct) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cell_mv        <= mv;
      req_last_cell      <= last;
      req_trip_used_raw  <= used;
      req_trip_regen_raw <= regen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cells_accepted++;
      if (last) frames_closed++;
      if (gauge_update(mv, last, used, regen, soc)) begin
         soc_expected.push_back((want >= 0) ? want[6:0] : soc);
      end
   endtask

   // Capacity changes only while the gauge is quiet, so drain the expected
   // readings and let the gauge settle before the write.
   task automatic set_capacity(input logic [15:0] cap);
      req_valid <= 1'b0;
      do @(posedge clock); while (soc_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_mah = cap;
   endtask

   task automatic run_phase(input int cells, input int send_pct, input int stall_pct,
                            input logic [15:0] cap, input bit drain_midway);
      int sent;
      int ncells;
      int c;
      bit drained;
      logic [15:0] mv;
      logic [31:0] used;
      logic [31:0] regen;
      longint unsigned span;
      set_capacity(cap);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      drained = 1'b0;
      span = (cap == 16'd0) ? 64'd100000 : longint'(cap) * 26000;
      while (sent < cells) begin
         if (drain_midway && !drained && sent >= cells / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (soc_expected.size() != 0);
            drained = 1'b1;
         end
         ncells = ($urandom_range(3, 0) == 0) ? 1 : $urandom_range(8, 2);
         regen = $urandom;
         // Mostly a discharge that lands within about 1.3 pack capacities.
         if ($urandom_range(99, 0) < 85) used = regen + $urandom_range(span[31:0], 0);
         else used = $urandom;
         for (c = 0; c < ncells; c++) begin
            if (c == 0 && $urandom_range(9, 0) == 0) mv = 16'd0;
            else if ($urandom_range(4, 0) == 0) mv = 16'($urandom);
            else mv = 16'($urandom_range(4400, 2500));
            if (c == ncells - 1) send_cell(mv, 1'b1, used, regen, PREDICT);
            else send_cell(mv, 1'b0, $urandom, $urandom, PREDICT);
         end
         sent += ncells;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (soc_expected.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got soc_percent %0d",
                     $time, rsp_soc_percent);
            mismatch_count++;
         end else begin
            soc_due = soc_expected.pop_front();
            readings_checked++;
            if (rsp_soc_percent !== soc_due) begin
               $display("%0t: soc_percent expected %0d, got %0d",
                        $time, soc_due, rsp_soc_percent);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("%0t: timed out with %0d readings outstanding", $time, soc_expected.size());
      $display("[battery_state_of_charge_gauge_top] ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_CAPACITY) begin
            set_capacity(directed_rows[i].cap);
         end else begin
            send_cell(directed_rows[i].mv, directed_rows[i].last, directed_rows[i].used,
                      directed_rows[i].regen, directed_rows[i].want);
         end
      end

      run_phase(225, 0, 0, 16'd5600, 1'b0);
      run_phase(225, 60, 0, 16'd1, 1'b0);
      run_phase(225, 0, 60, 16'd65535, 1'b0);
      run_phase(225, 30, 30, 16'($urandom_range(65535, 1)), 1'b0);
      run_phase(225, 0, 0, 16'd0, 1'b0);
      run_phase(225, 60, 0, 16'($urandom_range(9000, 100)), 1'b0);
      run_phase(225, 0, 60, 16'($urandom_range(65535, 1)), 1'b0);
      run_phase(225, 30, 30, 16'd5600, 1'b1);

      req_valid <= 1'b0;
      do @(posedge clock); while (soc_expected.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d cells in %0d frames and checked %0d charge readings,",
               cells_accepted, frames_closed, readings_checked);
      $display("with capacity from 0 to 65535 mAh under four idle and stall patterns.");
      if (mismatch_count == 0 && soc_expected.size() == 0) begin
         $display("[battery_state_of_charge_gauge_top] OK");
      end else begin
         $display("[battery_state_of_charge_gauge_top] ERROR");
      end
      $finish;
   end

endmodule
